/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// shared constants, types and command/status structs of the rational unit
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int NW = OPERAND_WIDTH;
  localparam int DW = OPERAND_WIDTH - 1;
  localparam int WW = 64;
  localparam int CW = 7;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD1,
    ST_LCM,
    ST_SCALE,
    ST_COMB,
    ST_GCD2,
    ST_RED,
    ST_OUT
  } state_t;

  // datapath micro-operations
  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_GCD1_INIT,
    DP_DIV_STEP,
    DP_GCD_SWAP,
    DP_LCM_MUL,
    DP_LCM_DIV2,
    DP_SCALE_A,
    DP_SCALE_B,
    DP_COMB,
    DP_MULDIV,
    DP_GCD2_INIT,
    DP_RED_NUM,
    DP_RED_DEN,
    DP_FINISH
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic err;
    logic is_addsub;
    logic div_done;
    logic rem_zero;
    logic mul_done;
  } stat_t;

endpackage

`default_nettype wire

/* sv/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// adds, subtracts, multiplies or divides two fractions, reduced by gcd
// ----------------------------------------------------------------------------
// acceptance to out_valid: a flagged error goes straight to output; otherwise
//   the path runs through the euclid remainder steps, longer for add and
//   subtract than for multiply and divide; a step is a restoring division
//   plus a swap
// throughput: one transaction in flight, next one taken the cycle after output
// reset: synchronous active-low rst_n returns the sequencer to idle
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [31:0] in_a_num,
  input  wire logic [30:0]        in_a_den,
  input  wire logic signed [31:0] in_b_num,
  input  wire logic [30:0]        in_b_den,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [63:0]      out_res_num,
  output logic [61:0]             out_res_den,
  output logic                    out_div_error
);

  // command and status between sequencer and datapath
  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // result registers hold steady while the output transaction waits
  rau_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .in_op    (in_op),
    .in_a_num (in_a_num),
    .in_a_den (in_a_den),
    .in_b_num (in_b_num),
    .in_b_den (in_b_den),
    .res_num  (out_res_num),
    .res_den  (out_res_den),
    .res_err  (out_div_error)
  );

endmodule

`default_nettype wire

/* sv/rau_datapath.sv */
// ----------------------------------------------------------------------------
// rau_datapath
// operand registers, shared restoring divider and shift-add multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module rau_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rau_pkg::ctrl_t              ctrl,
  output rau_pkg::stat_t                   stat,
  input  wire logic [1:0]                  in_op,
  input  wire logic signed [31:0]          in_a_num,
  input  wire logic [30:0]                 in_a_den,
  input  wire logic signed [31:0]          in_b_num,
  input  wire logic [30:0]                 in_b_den,
  output logic signed [63:0]               res_num,
  output logic [61:0]                      res_den,
  output logic                             res_err
);

  localparam int WW = rau_pkg::WW;

  logic [1:0]     op_r;
  logic [WW-1:0]  an_r, bn_r, ad_r, bd_r;
  logic           err_r;
  // divider: dividend q_r, divisor d_r, remainder rem_r
  logic [WW-1:0]  q_r, d_r, rem_r;
  logic [rau_pkg::CW-1:0] cnt_r;
  // multiplier: mc_r * mp_r accumulated into acc_r, 32 steps
  logic [WW-1:0]  mc_r, acc_r;
  logic [31:0]    mp_r;
  logic [WW-1:0]  x_r;
  logic [WW-1:0]  left_r, num_r, den_r, g_r;
  logic           neg_r;
  logic           mul_on_r;
  logic [1:0]     mul_dst_r;

  localparam logic [1:0] MD_LCM = 2'd0;
  localparam logic [1:0] MD_LEFT = 2'd1;
  localparam logic [1:0] MD_RIGHT = 2'd2;
  localparam logic [1:0] MD_DEN = 2'd3;

  logic [WW-1:0] an_w, bn_w, ad_w, bd_w;
  logic [WW:0]   rem_sh;
  logic [WW-1:0] bmag;

  always_comb begin
    an_w = {{(WW-rau_pkg::NW){in_a_num[rau_pkg::NW-1]}}, in_a_num[rau_pkg::NW-1:0]};
    bn_w = {{(WW-rau_pkg::NW){in_b_num[rau_pkg::NW-1]}}, in_b_num[rau_pkg::NW-1:0]};
    ad_w = {{(WW-rau_pkg::DW){1'b0}}, in_a_den[rau_pkg::DW-1:0]};
    bd_w = {{(WW-rau_pkg::DW){1'b0}}, in_b_den[rau_pkg::DW-1:0]};
    rem_sh = {rem_r, q_r[WW-1]};
    bmag = bn_r[WW-1] ? (64'd0 - bn_r) : bn_r;
  end

  // a negative 32-bit multiplier value is handled by magnitude for divide and by a product correction for multiply
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      mul_on_r <= 1'b0;
    end else begin
      if (mul_on_r) begin
        if (mp_r[0]) acc_r <= acc_r + mc_r;
        mc_r <= mc_r << 1;
        mp_r <= mp_r >> 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 7'd31) begin
          mul_on_r <= 1'b0;
        end
      end
      unique case (ctrl.cmd)
        rau_pkg::DP_LOAD: begin
          op_r <= in_op; an_r <= an_w; bn_r <= bn_w; ad_r <= ad_w; bd_r <= bd_w;
          err_r <= (ad_w == '0) || (bd_w == '0) ||
                   ((in_op == rau_pkg::OP_DIV) && (bn_w == '0));
        end
        rau_pkg::DP_GCD1_INIT: begin
          q_r <= ad_r; d_r <= bd_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_GCD2_INIT: begin
          neg_r <= num_r[WW-1];
          q_r <= num_r[WW-1] ? (64'd0 - num_r) : num_r;
          x_r <= num_r[WW-1] ? (64'd0 - num_r) : num_r;
          d_r <= den_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_DIV_STEP: begin
          if (rem_sh >= {1'b0, d_r}) begin
            rem_r <= rem_sh[WW-1:0] - d_r;
            q_r <= {q_r[WW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[WW-1:0];
            q_r <= {q_r[WW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
        end
        rau_pkg::DP_GCD_SWAP: begin
          // remainder becomes new divisor; g_r tracks last nonzero divisor
          g_r <= d_r;
          q_r <= d_r; d_r <= rem_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_LCM_MUL: begin
          // start ad/g: reuse divider
          q_r <= ad_r; d_r <= g_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_LCM_DIV2: begin
          // keep ad/g and start bd/g
          x_r <= q_r;
          q_r <= bd_r; d_r <= g_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_SCALE_A: begin
          // x_r = ad/g, q_r = bd/g; left = an*(bd/g) ; right = bn*(ad/g)
          // lcm = (ad/g)*bd
          acc_r <= '0; mc_r <= an_r; mp_r <= q_r[31:0];
          mul_on_r <= 1'b1; cnt_r <= '0; mul_dst_r <= MD_LEFT;
        end
        rau_pkg::DP_SCALE_B: begin
          // previous product done; stash it and start next
          unique case (mul_dst_r)
            MD_LEFT: begin
              left_r <= acc_r;
              acc_r <= '0; mc_r <= bn_r; mp_r <= x_r[31:0]; mul_dst_r <= MD_RIGHT;
            end
            MD_RIGHT: begin
              num_r <= (op_r == rau_pkg::OP_ADD) ? left_r + acc_r : left_r - acc_r;
              acc_r <= '0; mc_r <= x_r; mp_r <= bd_r[31:0]; mul_dst_r <= MD_LCM;
            end
            MD_LCM: begin
              den_r <= acc_r; mul_dst_r <= MD_DEN;
            end
            default: begin
              den_r <= acc_r;
            end
          endcase
          mul_on_r <= (mul_dst_r == MD_LEFT) || (mul_dst_r == MD_RIGHT);
          cnt_r <= '0;
        end
        rau_pkg::DP_MULDIV: begin
          // mul: num=an*bn, den=ad*bd ; div: num=+-an*bd, den=ad*|bn|
          if (op_r == rau_pkg::OP_MUL) begin
            mc_r <= an_r; mp_r <= bn_r[31:0];
          end else begin
            mc_r <= bn_r[WW-1] ? (64'd0 - an_r) : an_r; mp_r <= bd_r[31:0];
          end
          acc_r <= '0; mul_on_r <= 1'b1; cnt_r <= '0; mul_dst_r <= MD_LEFT;
        end
        rau_pkg::DP_COMB: begin
          unique case (mul_dst_r)
            MD_LEFT: begin
              // bn may be negative for mul: acc = an*low32(bn) mod 2^64 ; fix
              if (op_r == rau_pkg::OP_MUL && bn_r[WW-1])
                num_r <= acc_r - (an_r << 32);
              else
                num_r <= acc_r;
              acc_r <= '0; mc_r <= ad_r;
              mp_r <= (op_r == rau_pkg::OP_MUL) ? bd_r[31:0] : bmag[31:0];
              mul_dst_r <= MD_DEN;
            end
            default: begin
              den_r <= acc_r;
            end
          endcase
          mul_on_r <= (mul_dst_r == MD_LEFT);
          cnt_r <= '0;
        end
        rau_pkg::DP_RED_NUM: begin
          q_r <= x_r; d_r <= g_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_RED_DEN: begin
          num_r <= neg_r ? (64'd0 - q_r) : q_r;
          q_r <= den_r; d_r <= g_r; rem_r <= '0; cnt_r <= '0;
        end
        rau_pkg::DP_FINISH: begin
          den_r <= q_r;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    stat.err = err_r;
    stat.is_addsub = (op_r == rau_pkg::OP_ADD) || (op_r == rau_pkg::OP_SUB);
    stat.div_done = (cnt_r == 7'd64);
    stat.rem_zero = (d_r == '0);
    stat.mul_done = !mul_on_r;
    res_num = err_r ? 64'sd0 : $signed(num_r);
    res_den = err_r ? 62'd1 : den_r[61:0];
    res_err = err_r;
  end

endmodule

`default_nettype wire

/* sv/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer issuing datapath commands for one transaction at a time
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rau_pkg::stat_t stat,
  output rau_pkg::ctrl_t      ctrl
);

  rau_pkg::state_t state_r, state_nxt;
  logic [1:0] ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::ST_IDLE;
      ph_r <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    ctrl.cmd = rau_pkg::DP_NONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.cmd = rau_pkg::DP_LOAD;
          state_nxt = rau_pkg::ST_GCD1;
          ph_nxt = 2'd0;
        end
      end
      rau_pkg::ST_GCD1: begin
        // ph 0: init or start mul/div ; ph 1: euclid loop for gcd(ad,bd)
        if (stat.err) begin
          state_nxt = rau_pkg::ST_OUT;
        end else if (ph_r == 2'd0) begin
          ph_nxt = 2'd1;
          if (stat.is_addsub) begin
            ctrl.cmd = rau_pkg::DP_GCD1_INIT;
          end else begin
            ctrl.cmd = rau_pkg::DP_MULDIV;
            state_nxt = rau_pkg::ST_COMB;
            ph_nxt = 2'd0;
          end
        end else if (stat.rem_zero) begin
          ctrl.cmd = rau_pkg::DP_LCM_MUL;
          state_nxt = rau_pkg::ST_LCM;
          ph_nxt = 2'd0;
        end else if (stat.div_done) begin
          ctrl.cmd = rau_pkg::DP_GCD_SWAP;
        end else begin
          ctrl.cmd = rau_pkg::DP_DIV_STEP;
        end
      end
      rau_pkg::ST_LCM: begin
        // ph 0: ad/g ; ph 1: bd/g
        if (stat.div_done) begin
          if (ph_r == 2'd0) begin
            ctrl.cmd = rau_pkg::DP_LCM_DIV2;
            ph_nxt = 2'd1;
          end else begin
            ctrl.cmd = rau_pkg::DP_SCALE_A;
            state_nxt = rau_pkg::ST_SCALE;
            ph_nxt = 2'd0;
          end
        end else begin
          ctrl.cmd = rau_pkg::DP_DIV_STEP;
        end
      end
      rau_pkg::ST_SCALE: begin
        if (stat.mul_done) begin
          ctrl.cmd = rau_pkg::DP_SCALE_B;
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd2) begin
            state_nxt = rau_pkg::ST_GCD2;
            ph_nxt = 2'd0;
          end
        end
      end
      rau_pkg::ST_COMB: begin
        if (stat.mul_done) begin
          ctrl.cmd = rau_pkg::DP_COMB;
          ph_nxt = ph_r + 2'd1;
          if (ph_r == 2'd1) begin
            state_nxt = rau_pkg::ST_GCD2;
            ph_nxt = 2'd0;
          end else begin
            ph_nxt = 2'd1;
          end
        end
      end
      rau_pkg::ST_GCD2: begin
        // d starts at den (nonzero), so first swap leaves g = den if num 0
        if (ph_r == 2'd0) begin
          ctrl.cmd = rau_pkg::DP_GCD2_INIT;
          ph_nxt = 2'd1;
        end else if (stat.rem_zero) begin
          ctrl.cmd = rau_pkg::DP_RED_NUM;
          state_nxt = rau_pkg::ST_RED;
          ph_nxt = 2'd0;
        end else if (stat.div_done) begin
          ctrl.cmd = rau_pkg::DP_GCD_SWAP;
        end else begin
          ctrl.cmd = rau_pkg::DP_DIV_STEP;
        end
      end
      rau_pkg::ST_RED: begin
        if (stat.div_done) begin
          if (ph_r == 2'd0) begin
            ctrl.cmd = rau_pkg::DP_RED_DEN;
            ph_nxt = 2'd1;
          end else begin
            ctrl.cmd = rau_pkg::DP_FINISH;
            state_nxt = rau_pkg::ST_OUT;
          end
        end else begin
          ctrl.cmd = rau_pkg::DP_DIV_STEP;
        end
      end
      rau_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = rau_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rau_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
